// ===== rtl/rq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible queue package
// Shared types and codes for the reversible queue: opcodes, status codes and
// the packed command and result items.
// ----------------------------------------------------------------------------
package rq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic        [4:0]  occupancy;
        logic               is_empty;
        logic               reversed;
        t_status            status;
    } t_out;

endpackage
`default_nettype wire

// ===== rtl/rq_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible queue word store
// Ring storage with one write port and two registered read ports. A read of
// the address written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module rq_ring #(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [31:0]              i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [31:0]              o_rd_data_a,
    output logic      [31:0]              o_rd_data_b
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            o_rd_data_a <= i_wr_data;
        end else begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            o_rd_data_b <= i_wr_data;
        end else begin
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rq_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible queue control
// Head pointer, word count, direction flag and cached end words. Computes
// the next state and the result for one command in a single pass.
// ----------------------------------------------------------------------------
module rq_core
    import rq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire t_in                      i_item,
    input  wire logic [31:0]              i_second,
    input  wire logic [31:0]              i_penult,
    output t_out                          o_result,
    output logic                          o_wr_en,
    output logic      [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic      [31:0]              o_wr_data,
    output logic      [$clog2(DEPTH)-1:0] o_rd_addr_a,
    output logic      [$clog2(DEPTH)-1:0] o_rd_addr_b
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [SW-1:0] DEPTH2_S = SW'(2 * DEPTH);

    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_dir,   n_dir;
    logic [31:0]   r_first, n_first;
    logic [31:0]   r_last,  n_last;
    t_status       w_status;

    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] w_head_dec;
    logic [SW-1:0] w_tail_sum;
    logic [SW-1:0] w_tail_red;
    logic [SW-1:0] w_pen_sum;
    logic [SW-1:0] w_pen_red;
    logic [CW+4:0] w_count_wide;

    assign w_head_inc = (r_head == LAST_POS) ? '0 : r_head + 1'b1;
    assign w_head_dec = (r_head == '0) ? LAST_POS : r_head - 1'b1;

    // Physical slot just past the last word, used by a push in normal order.
    assign w_tail_sum = SW'(r_head) + SW'(r_count);
    assign w_tail_red = (w_tail_sum >= DEPTH_S) ? w_tail_sum - DEPTH_S : w_tail_sum;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_dir    = r_dir;
        n_first  = r_first;
        n_last   = r_last;
        w_status = ST_OK;
        o_wr_en  = 1'b0;
        o_wr_addr = w_tail_red[AW-1:0];
        o_wr_data = i_item.push_value;
        if (i_accept) begin
            case (i_item.opcode)
                OP_PUSH: begin
                    if (r_count == DEPTH_C) begin
                        w_status = ST_PUSH_FULL;
                    end else begin
                        o_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_dir) begin
                            n_head    = w_head_dec;
                            o_wr_addr = w_head_dec;
                            n_first   = i_item.push_value;
                            if (r_count == '0) begin
                                n_last = i_item.push_value;
                            end
                        end else begin
                            n_last = i_item.push_value;
                            if (r_count == '0) begin
                                n_first = i_item.push_value;
                            end
                        end
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        w_status = ST_POP_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (r_dir) begin
                            n_last = i_penult;
                        end else begin
                            n_head  = w_head_inc;
                            n_first = i_second;
                        end
                    end
                end
                OP_TOGGLE: begin
                    n_dir = ~r_dir;
                end
                default: begin
                end
            endcase
        end
    end

    // Prefetch the neighbors of both ends for the state after this cycle.
    assign o_rd_addr_a = (n_head == LAST_POS) ? '0 : n_head + 1'b1;
    assign w_pen_sum   = SW'(n_head) + SW'(n_count) + DEPTH_S - SW'(2);
    always_comb begin
        if (w_pen_sum >= DEPTH2_S) begin
            w_pen_red = w_pen_sum - DEPTH2_S;
        end else if (w_pen_sum >= DEPTH_S) begin
            w_pen_red = w_pen_sum - DEPTH_S;
        end else begin
            w_pen_red = w_pen_sum;
        end
    end
    assign o_rd_addr_b = w_pen_red[AW-1:0];

    assign w_count_wide = {5'b0, n_count};

    always_comb begin
        o_result.occupancy = w_count_wide[4:0];
        o_result.is_empty  = (n_count == '0);
        o_result.reversed  = n_dir;
        o_result.status    = w_status;
        if (n_count == '0) begin
            o_result.front_value = '0;
            o_result.back_value  = '0;
        end else if (n_dir) begin
            o_result.front_value = n_last;
            o_result.back_value  = n_first;
        end else begin
            o_result.front_value = n_first;
            o_result.back_value  = n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_dir   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_dir   <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_last  <= n_last;
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= DEPTH_C;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("word count exceeds depth");

    property p_full_holds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_status == ST_PUSH_FULL) |-> (n_count == r_count) && (n_head == r_head);
    endproperty
    a_full_holds: assert property (p_full_holds)
        else $error("dropped push changed the queue");

    property p_pop_empty_holds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_status == ST_POP_EMPTY) |-> (r_count == '0) && (n_count == '0);
    endproperty
    a_pop_empty_holds: assert property (p_pop_empty_holds)
        else $error("ignored pop changed the queue");

endmodule
`default_nettype wire

// ===== rtl/reversible_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible queue top level
// Bounded queue of signed 32-bit words with a direction flag, driven by
// push, pop, toggle and query commands, one result per command.
// ----------------------------------------------------------------------------
// The result of a command is registered and strobed on o_valid in the cycle
// after the transfer that carried it in.
// Throughput: one command per cycle; o_busy is always low, since each command
// moves one pointer and one count and the ring prefetches both end neighbors.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset (synchronous, active low) empties the queue and clears the direction
// flag; the word store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module reversible_queue_top
    import rq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_item,
    output logic      o_busy,
    output logic      o_valid,
    output t_out      o_result
);

    localparam int AW = $clog2(DEPTH);

    // A command transfer takes place whenever start is high; the block never
    // pushes back, so busy is held low.
    logic w_accept;

    // Write and prefetch ports between the control logic and the word store.
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr_a;
    logic [AW-1:0] w_rd_addr_b;
    logic [31:0]   w_second;
    logic [31:0]   w_penult;

    // Result computed in the same cycle as the command transfer.
    t_out w_result;

    logic r_valid;
    t_out r_result;

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // The control keeps the physical first and last words in registers, so a
    // push never has to read the store. A pop needs the word next to the end
    // it removes; the store keeps that word prefetched for the current state.
    rq_core #(
        .DEPTH(DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_second    (w_second),
        .i_penult    (w_penult),
        .o_result    (w_result),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b)
    );

    // The store is read at the addresses of the next state. A word written
    // in the same cycle is forwarded, so the prefetched neighbors are always
    // current when the following command arrives.
    rq_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_second),
        .o_rd_data_b (w_penult)
    );

    // Result register: the strobe is the only control bit that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    property p_strobe_follows;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> o_valid;
    endproperty
    a_strobe_follows: assert property (p_strobe_follows)
        else $error("command transfer produced no result");

    property p_no_spurious;
        @(posedge i_clk) disable iff (!i_rst_n) !i_start |=> !o_valid;
    endproperty
    a_no_spurious: assert property (p_no_spurious)
        else $error("result strobed without a command");

    property p_empty_reads_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && o_result.is_empty) |->
                (o_result.front_value == '0) && (o_result.back_value == '0);
    endproperty
    a_empty_reads_zero: assert property (p_empty_reads_zero)
        else $error("empty queue reported nonzero end words");

    property p_pop_empty_flag;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && (o_result.status == ST_POP_EMPTY)) |-> o_result.is_empty;
    endproperty
    a_pop_empty_flag: assert property (p_pop_empty_flag)
        else $error("ignored pop reported a nonempty queue");

endmodule
`default_nettype wire

// ===== tb/tb_reversible_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible queue testbench
// Drives push, pop, toggle and query commands into the reversible queue and
// checks every result against a shadow queue kept in the testbench. A short
// directed part covers the empty and full boundaries, extreme words and both
// directions. Random traffic with fill and drain bursts follows, under
// three sender idle rates.
// ----------------------------------------------------------------------------
module tb_reversible_queue_top;
    import rq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RESET_CYCLES   = 7;
    // Cycles without any transfer before the run is declared hung. The sender
    // idles only in random stretches between commands, and the block answers
    // every command on the next cycle.
    localparam int WATCHDOG_LIMIT = 2000;
    // The block answers in the cycle after a transfer. Spare cycles at the
    // end catch any result that should not be there.
    localparam int TAIL_CYCLES    = 4;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item  = '0;
    logic o_busy;
    logic o_valid;
    t_out o_result;

    // Shadow copy of the queue. Words sit in physical order from
    // shadow_head onward, exactly as in the block.
    logic signed [31:0] shadow_words [QUEUE_DEPTH];
    int                 shadow_head     = 0;
    int                 shadow_count    = 0;
    logic               shadow_reversed = 1'b0;

    // Queue views that the block still owes, oldest first.
    t_out expected_views [$];

    int error_count     = 0;
    int idle_cycles     = 0;
    int sender_idle_pct = 0;

    always #6 i_clk = ~i_clk;

    reversible_queue_top #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // Applies one command to the shadow queue and returns the view of the
    // queue after it: both logical ends, the fill level, the direction and
    // the status of the command.
    function automatic t_out step_shadow_queue(input t_in cmd);
        t_out               view;
        logic signed [31:0] first_word;
        logic signed [31:0] last_word;

        view        = '0;
        view.status = ST_OK;
        first_word  = '0;
        last_word   = '0;
        case (cmd.opcode)
            OP_PUSH: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    view.status = ST_PUSH_FULL;
                end else if (shadow_reversed) begin
                    // The logical tail is in front of the first physical word.
                    shadow_head = (shadow_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    shadow_words[shadow_head] = cmd.push_value;
                    shadow_count++;
                end else begin
                    shadow_words[(shadow_head + shadow_count) % QUEUE_DEPTH] = cmd.push_value;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    view.status = ST_POP_EMPTY;
                end else if (shadow_reversed) begin
                    // The logical head is the last physical word.
                    shadow_count--;
                end else begin
                    shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
                    shadow_count--;
                end
            end
            OP_TOGGLE: shadow_reversed = ~shadow_reversed;
            default: ;
        endcase
        // Both ends read zero when the queue is empty.
        if (shadow_count != 0) begin
            first_word = shadow_words[shadow_head];
            last_word  = shadow_words[(shadow_head + shadow_count - 1) % QUEUE_DEPTH];
        end
        view.front_value = shadow_reversed ? last_word : first_word;
        view.back_value  = shadow_reversed ? first_word : last_word;
        view.occupancy   = 5'(shadow_count);
        view.is_empty    = (shadow_count == 0);
        view.reversed    = shadow_reversed;
        return view;
    endfunction

    // Offers one command and holds it until the block takes it. The sender
    // may first sit idle for a random number of cycles. The start line is
    // left high after the transfer, so back-to-back commands need no second
    // assignment in the same time step.
    task automatic send_command(input t_opcode op, input logic signed [31:0] value);
        t_in cmd;

        cmd.opcode     = op;
        cmd.push_value = value;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= cmd;
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        expected_views.push_back(step_shadow_queue(cmd));
    endtask

    // The sender stops until the block has answered every command so far.
    task automatic wait_for_all_results();
        i_start <= 1'b0;
        while (expected_views.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Empty queue: query, pop in both directions (both must be ignored) and
    // a toggle with no words stored.
    task automatic test_empty_queue();
        send_command(OP_QUERY, 32'sd0);
        send_command(OP_POP, 32'sh1234_5678);
        send_command(OP_TOGGLE, 32'sd0);
        send_command(OP_POP, -32'sd1);
    endtask

    // Extreme words, pushed first while reversed and then in normal order, so
    // that both push paths are taken; a query and a pop in normal order follow.
    task automatic test_extreme_words();
        send_command(OP_PUSH, 32'sh8000_0000);
        send_command(OP_PUSH, 32'sh7FFF_FFFF);
        send_command(OP_TOGGLE, 32'sd0);
        send_command(OP_PUSH, 32'sd0);
        send_command(OP_PUSH, -32'sd1);
        send_command(OP_QUERY, 32'sh5555_5555);
        send_command(OP_POP, 32'shAAAA_AAAA);
    endtask

    // Fills the queue, then pushes onto a full queue in both directions and
    // pops once while reversed at full level.
    task automatic test_full_queue();
        int k;

        k = 0;
        while (shadow_count < QUEUE_DEPTH) begin
            send_command(OP_PUSH, 32'sh0101_0101 * (k + 1));
            k++;
        end
        send_command(OP_PUSH, 32'shDEAD_BEEF);
        send_command(OP_TOGGLE, 32'sd0);
        send_command(OP_PUSH, 32'sh0BAD_F00D);
        send_command(OP_POP, 32'sd0);
        send_command(OP_TOGGLE, 32'sd0);
    endtask

    // Random traffic in bursts. Each burst leans toward filling, draining or
    // neither, so the fill level keeps sweeping between empty and full and
    // the wrap of the ring is crossed many times in both directions.
    task automatic test_random_traffic(input int n_commands, input int idle_pct);
        int                 sent;
        int                 burst_left;
        int                 push_weight;
        int                 pick;
        t_opcode            op;
        logic signed [31:0] value;

        sender_idle_pct = idle_pct;
        sent            = 0;
        burst_left      = 0;
        push_weight     = 50;
        while (sent < n_commands) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_weight = 80;
                    1: push_weight = 20;
                    default: push_weight = 50;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                op = OP_TOGGLE;
            end else if (pick < 16) begin
                op = OP_QUERY;
            end else if ($urandom_range(0, 99) < push_weight) begin
                op = OP_PUSH;
            end else begin
                op = OP_POP;
            end
            // Mostly full-range words, with the corner words mixed in.
            case ($urandom_range(0, 9))
                0: value = 32'sh8000_0000;
                1: value = 32'sh7FFF_FFFF;
                2: value = 32'sd0;
                3: value = -32'sd1;
                default: value = $urandom();
            endcase
            send_command(op, value);
            sent++;
            burst_left--;
        end
    endtask

    task automatic report_mismatch(input string field_name, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, field_name, want, got);
        error_count++;
    endtask

    // Each result lives on the ports for one cycle and is taken at the edge
    // that ends that cycle. It is compared with the oldest expected view.
    always @(posedge i_clk) begin
        t_out want;

        if (i_rst_n && o_valid) begin
            if (expected_views.size() == 0) begin
                $display("%0t: result with no command pending, expected none, actual %h",
                         $time, o_result);
                error_count++;
            end else begin
                want = expected_views.pop_front();
                if (o_result.front_value !== want.front_value)
                    report_mismatch("front_value", want.front_value, o_result.front_value);
                if (o_result.back_value !== want.back_value)
                    report_mismatch("back_value", want.back_value, o_result.back_value);
                if (o_result.occupancy !== want.occupancy)
                    report_mismatch("occupancy", want.occupancy, o_result.occupancy);
                if (o_result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", want.is_empty, o_result.is_empty);
                if (o_result.reversed !== want.reversed)
                    report_mismatch("reversed", want.reversed, o_result.reversed);
                if (o_result.status !== want.status)
                    report_mismatch("status", want.status, o_result.status);
            end
        end
    end

    // Watchdog: counts cycles with neither a command transfer nor a result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (shadow_words[k]) shadow_words[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part and the first random phase run with a light sender.
        sender_idle_pct = 13;
        test_empty_queue();
        test_extreme_words();
        test_full_queue();
        test_random_traffic(570, 13);
        wait_for_all_results();
        // A heavily idling sender, then commands on every cycle.
        test_random_traffic(570, 74);
        wait_for_all_results();
        test_random_traffic(570, 0);
        wait_for_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
